[hdl/qsl_pkg.sv]
// Shared constants, payload struct and arctangent table for the quaternion slerp pipeline.
`timescale 1ns / 1ps

package qsl_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int ROT_LANES         = 3;
    localparam int DIV_LANES         = 2;
    localparam int CW                = 34;   // CORDIC datapath width
    localparam int QW                = 17;   // Q.16 weight width, holds 1.0
    localparam int RAD_W             = 61;   // sqrt radicand, up to 2^60
    localparam int ROOT_W            = 31;   // sqrt root, up to 2^30

    localparam logic [14:0] THR_RESET = 15'd16376;
    localparam logic [16:0] ONE_Q16   = 17'd65536;

    // Per-item data that rides alongside the arithmetic
    typedef struct packed {
        logic [3:0][15:0] s;     // start components
        logic [3:0][16:0] e;     // end components, negated for the short arc
        logic [16:0]      t;     // blend fraction, 0..65536 when t_ok
        logic [30:0]      cq;    // cosine in Q.30, clamped to 1.0
        logic             t_ok;  // fraction within 0..1
        logic             sph;   // spherical weights apply
    } side_t;

    // Truncated arctangent of 2^-i in Q.30
    function automatic logic [29:0] atan_q30(input int i);
        logic [29:0] r;
        case (i)
            0:  r = 30'd843314856;
            1:  r = 30'd497837829;
            2:  r = 30'd263043836;
            3:  r = 30'd133525158;
            4:  r = 30'd67021686;
            5:  r = 30'd33543515;
            6:  r = 30'd16775850;
            7:  r = 30'd8388437;
            8:  r = 30'd4194282;
            9:  r = 30'd2097149;
            10: r = 30'd1048575;
            11: r = 30'd524287;
            12: r = 30'd262143;
            13: r = 30'd131071;
            14: r = 30'd65535;
            15: r = 30'd32767;
            16: r = 30'd16383;
            17: r = 30'd8191;
            18: r = 30'd4095;
            19: r = 30'd2047;
            20: r = 30'd1023;
            21: r = 30'd511;
            22: r = 30'd255;
            23: r = 30'd127;
            24: r = 30'd63;
            25: r = 30'd31;
            26: r = 30'd15;
            27: r = 30'd7;
            28: r = 30'd3;
            29: r = 30'd1;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

[hdl/quaternion_slerp_top.sv]
// Top level of the quaternion slerp pipeline: front end, angle and weight units, blend.
`timescale 1ns / 1ps

// Quaternion slerp, fully pipelined: one request is accepted every clock cycle unless a
// result is held at the output. Each result passes the 31-stage square root, the
// vectoring and rotation CORDIC chains of CORDIC_STAGES stages each, the 17-stage weight
// dividers and seven pipeline registers around them. All stages move together; while a
// result waits at the output with m_ready low, s_ready is low and the pipeline holds its
// contents. The threshold register is written through cfg_valid/cfg_ready, which is always
// ready, and should change only while no request is in flight.

module quaternion_slerp_top #(
    parameter int CORDIC_STAGES = qsl_pkg::CORDIC_STAGES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [14:0]        cfg_linear_cos_threshold,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_start_w,
    input  logic signed [15:0] s_start_x,
    input  logic signed [15:0] s_start_y,
    input  logic signed [15:0] s_start_z,
    input  logic signed [15:0] s_end_w,
    input  logic signed [15:0] s_end_x,
    input  logic signed [15:0] s_end_y,
    input  logic signed [15:0] s_end_z,
    input  logic signed [17:0] s_blend_fraction,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_out_w,
    output logic signed [15:0] m_out_x,
    output logic signed [15:0] m_out_y,
    output logic signed [15:0] m_out_z,
    output logic               m_result_valid
);
    import qsl_pkg::*;

    localparam logic [32:0]      ONE_Q28 = 33'd268435456;
    localparam logic [30:0]      ONE_Q30 = 31'd1073741824;
    localparam logic [RAD_W-1:0] ONE_Q60 = RAD_W'(1) << 60;

    logic        en;
    logic [14:0] thr_reg;

    // threshold register
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= THR_RESET;
        end else if (cfg_valid) begin
            thr_reg <= cfg_linear_cos_threshold;
        end
    end

    // whole pipeline advances unless the output holds an untaken result
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // stage F1: capture and partial products
    logic signed [15:0] s_in [4];
    logic signed [15:0] e_in [4];

    assign s_in[0] = s_start_w;
    assign s_in[1] = s_start_x;
    assign s_in[2] = s_start_y;
    assign s_in[3] = s_start_z;
    assign e_in[0] = s_end_w;
    assign e_in[1] = s_end_x;
    assign e_in[2] = s_end_y;
    assign e_in[3] = s_end_z;

    logic               f1_vld_reg;
    logic signed [15:0] f1_s_reg [4];
    logic signed [15:0] f1_e_reg [4];
    logic signed [31:0] f1_p_reg [4];
    logic signed [17:0] f1_t_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_vld_reg <= 1'b0;
        end else if (en) begin
            f1_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f1_t_reg <= s_blend_fraction;
            for (int k = 0; k < 4; k++) begin
                f1_s_reg[k] <= s_in[k];
                f1_e_reg[k] <= e_in[k];
                f1_p_reg[k] <= s_in[k] * e_in[k];
            end
        end
    end

    // stage F2: dot product, short-arc flip, threshold test, clamped cosine
    logic signed [33:0] c_c;
    logic               c_neg;
    logic [32:0]        cabs_c;
    side_t              f2_side_next;

    assign c_c    = 34'(f1_p_reg[0]) + 34'(f1_p_reg[1]) + 34'(f1_p_reg[2]) + 34'(f1_p_reg[3]);
    assign c_neg  = (c_c < 0);
    assign cabs_c = 33'(c_neg ? -c_c : c_c);

    always_comb begin
        logic signed [16:0] ex;
        f2_side_next = '0;
        for (int k = 0; k < 4; k++) begin
            ex                = 17'(f1_e_reg[k]);
            f2_side_next.s[k] = f1_s_reg[k];
            f2_side_next.e[k] = c_neg ? -ex : ex;
        end
        f2_side_next.t    = f1_t_reg[16:0];
        f2_side_next.t_ok = (f1_t_reg >= 0) && (f1_t_reg <= 18'sd65536);
        f2_side_next.sph  = !(cabs_c > {4'b0, thr_reg, 14'b0});
        f2_side_next.cq   = (cabs_c > ONE_Q28) ? ONE_Q30 : {cabs_c[28:0], 2'b00};
    end

    logic  f2_vld_reg;
    side_t f2_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f2_vld_reg <= 1'b0;
        end else if (en) begin
            f2_vld_reg <= f1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f2_side_reg <= f2_side_next;
        end
    end

    // stage F3: cosine squared
    logic [61:0]      sq_full;
    logic             f3_vld_reg;
    side_t            f3_side_reg;
    logic [RAD_W-1:0] f3_sq_reg;

    assign sq_full = {31'b0, f2_side_reg.cq} * {31'b0, f2_side_reg.cq};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f3_vld_reg <= 1'b0;
        end else if (en) begin
            f3_vld_reg <= f2_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f3_side_reg <= f2_side_reg;
            f3_sq_reg   <= sq_full[RAD_W-1:0];
        end
    end

    // stage F4: radicand 1 - c^2 in Q.60
    logic             f4_vld_reg;
    side_t            f4_side_reg;
    logic [RAD_W-1:0] f4_rad_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f4_vld_reg <= 1'b0;
        end else if (en) begin
            f4_vld_reg <= f3_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f4_side_reg <= f3_side_reg;
            f4_rad_reg  <= ONE_Q60 - f3_sq_reg;
        end
    end

    // sine of the angle
    logic              sq_vld;
    logic [ROOT_W-1:0] sq_root;
    side_t             sq_side;
    side_t             vec_side_in;

    qsl_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_vld   (f4_vld_reg),
        .rad_in   (f4_rad_reg),
        .side_in  (f4_side_reg),
        .out_vld  (sq_vld),
        .root_out (sq_root),
        .side_out (sq_side)
    );

    // zero sine falls back to linear weights
    always_comb begin
        vec_side_in     = sq_side;
        vec_side_in.sph = sq_side.sph && (sq_root != '0);
    end

    logic                 vec_vld;
    logic signed [CW-1:0] vec_z;
    side_t                vec_side;

    qsl_cordic_vec #(
        .STAGES (CORDIC_STAGES)
    ) u_vec (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_vld   (sq_vld),
        .x_in     ($signed(CW'(sq_side.cq))),
        .y_in     ($signed(CW'(sq_root))),
        .side_in  (vec_side_in),
        .out_vld  (vec_vld),
        .z_out    (vec_z),
        .side_out (vec_side)
    );

    // stage H1: clamp the angle and split it by the blend fraction
    logic [31:0] a_c;
    logic [48:0] th0_full;
    logic [48:0] th1_full;
    logic        h1_vld_reg;
    side_t       h1_side_reg;
    logic [31:0] h1_a_reg;
    logic [31:0] h1_th0_reg;
    logic [31:0] h1_th1_reg;

    assign a_c      = (vec_z < 0) ? '0 : vec_z[31:0];
    assign th0_full = {32'b0, ONE_Q16 - vec_side.t} * {17'b0, a_c};
    assign th1_full = {32'b0, vec_side.t} * {17'b0, a_c};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            h1_vld_reg <= 1'b0;
        end else if (en) begin
            h1_vld_reg <= vec_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            h1_side_reg <= vec_side;
            h1_a_reg    <= a_c;
            h1_th0_reg  <= th0_full[47:16];
            h1_th1_reg  <= th1_full[47:16];
        end
    end

    // lane 0: sin a, lane 1: sin((1-t)a), lane 2: sin(ta)
    logic [ROT_LANES-1:0][CW-1:0] rot_z;
    logic                         rot_vld;
    logic [ROT_LANES-1:0][CW-1:0] rot_y;
    side_t                        rot_side;
    side_t                        div_side_in;

    assign rot_z[0] = CW'(h1_a_reg);
    assign rot_z[1] = CW'(h1_th0_reg);
    assign rot_z[2] = CW'(h1_th1_reg);

    qsl_cordic_rot #(
        .STAGES (CORDIC_STAGES),
        .LANES  (ROT_LANES)
    ) u_rot (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_vld   (h1_vld_reg),
        .z_in     (rot_z),
        .side_in  (h1_side_reg),
        .out_vld  (rot_vld),
        .y_out    (rot_y),
        .side_out (rot_side)
    );

    // degenerate angle falls back to linear weights
    always_comb begin
        div_side_in     = rot_side;
        div_side_in.sph = rot_side.sph && ($signed(rot_y[0]) > 0);
    end

    logic [DIV_LANES-1:0][CW-1:0] div_num;
    logic                         div_vld;
    logic [DIV_LANES-1:0][QW-1:0] div_q;
    side_t                        div_side;

    assign div_num[0] = rot_y[1];
    assign div_num[1] = rot_y[2];

    qsl_div #(
        .LANES (DIV_LANES)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_vld   (rot_vld),
        .num_in   (div_num),
        .den_in   ($signed(rot_y[0])),
        .side_in  (div_side_in),
        .out_vld  (div_vld),
        .q_out    (div_q),
        .side_out (div_side)
    );

    // stage B1: weight select and weighted products
    logic signed [17:0] w0_s;
    logic signed [17:0] w1_s;
    logic               b1_vld_reg;
    logic               b1_t_ok_reg;
    logic signed [33:0] b1_p0_reg [4];
    logic signed [34:0] b1_p1_reg [4];

    assign w0_s = $signed({1'b0, div_side.sph ? div_q[0] : (ONE_Q16 - div_side.t)});
    assign w1_s = $signed({1'b0, div_side.sph ? div_q[1] : div_side.t});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b1_vld_reg <= 1'b0;
        end else if (en) begin
            b1_vld_reg <= div_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b1_t_ok_reg <= div_side.t_ok;
            for (int k = 0; k < 4; k++) begin
                b1_p0_reg[k] <= $signed(div_side.s[k]) * w0_s;
                b1_p1_reg[k] <= $signed(div_side.e[k]) * w1_s;
            end
        end
    end

    // output stage: sum, round to Q.14, saturate, zero a rejected fraction
    logic signed [35:0] sum_c [4];
    logic signed [35:0] rnd_c [4];
    logic [15:0]        sat_c [4];

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            sum_c[k] = 36'(b1_p0_reg[k]) + 36'(b1_p1_reg[k]) + 36'sd32768;
            rnd_c[k] = sum_c[k] >>> 16;
            if (!b1_t_ok_reg) begin
                sat_c[k] = '0;
            end else if (rnd_c[k] > 36'sd32767) begin
                sat_c[k] = 16'h7FFF;
            end else if (rnd_c[k] < -36'sd32768) begin
                sat_c[k] = 16'h8000;
            end else begin
                sat_c[k] = rnd_c[k][15:0];
            end
        end
    end

    logic        m_valid_reg;
    logic [15:0] out_reg [4];
    logic        result_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= b1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            result_valid_reg <= b1_t_ok_reg;
            for (int k = 0; k < 4; k++) begin
                out_reg[k] <= sat_c[k];
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_out_w        = $signed(out_reg[0]);
    assign m_out_x        = $signed(out_reg[1]);
    assign m_out_y        = $signed(out_reg[2]);
    assign m_out_z        = $signed(out_reg[3]);
    assign m_result_valid = result_valid_reg;

`ifndef NO_ASSERTIONS
    // a rejected fraction must come out as an all-zero quaternion
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_result_valid |->
            (m_out_w == 0 && m_out_x == 0 && m_out_y == 0 && m_out_z == 0))
        else $error("invalid result carries nonzero components");

    // a held result blocks new requests
    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("request accepted while output stalled");

    // the two partial angles never exceed the full angle
    a_angle_split: assert property (@(posedge aclk) disable iff (!aresetn)
        h1_vld_reg && h1_side_reg.t_ok |->
            ({1'b0, h1_th0_reg} + {1'b0, h1_th1_reg} <= {1'b0, h1_a_reg}))
        else $error("partial angles exceed the full angle");
`endif

endmodule

[hdl/qsl_sqrt.sv]
// Pipelined integer square root, one root bit per register stage.
`timescale 1ns / 1ps

module qsl_sqrt (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_vld,
    input  logic [qsl_pkg::RAD_W-1:0]   rad_in,
    input  qsl_pkg::side_t              side_in,
    output logic                        out_vld,
    output logic [qsl_pkg::ROOT_W-1:0]  root_out,
    output qsl_pkg::side_t              side_out
);
    import qsl_pkg::*;

    localparam int NS = ROOT_W;

    logic             vld_reg  [NS];
    logic [RAD_W-1:0] v_reg    [NS];
    logic [RAD_W:0]   res_reg  [NS];
    side_t            side_reg [NS];

    for (genvar j = 0; j < NS; j++) begin : g_stage
        localparam logic [RAD_W:0] BIT = (RAD_W + 1)'(1) << (2 * (NS - 1 - j));

        logic             vld_i;
        logic [RAD_W-1:0] v_i;
        logic [RAD_W:0]   res_i;
        logic [RAD_W:0]   trial;
        side_t            side_i;

        if (j == 0) begin : g_first
            assign vld_i  = in_vld;
            assign v_i    = rad_in;
            assign res_i  = '0;
            assign side_i = side_in;
        end else begin : g_next
            assign vld_i  = vld_reg[j-1];
            assign v_i    = v_reg[j-1];
            assign res_i  = res_reg[j-1];
            assign side_i = side_reg[j-1];
        end

        assign trial = res_i + BIT;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[j] <= 1'b0;
            end else if (en) begin
                vld_reg[j] <= vld_i;
            end
        end

        // restoring step: subtract when the trial fits
        always_ff @(posedge aclk) begin
            if (en) begin
                side_reg[j] <= side_i;
                if ({1'b0, v_i} >= trial) begin
                    v_reg[j]   <= RAD_W'({1'b0, v_i} - trial);
                    res_reg[j] <= (res_i >> 1) + BIT;
                end else begin
                    v_reg[j]   <= v_i;
                    res_reg[j] <= res_i >> 1;
                end
            end
        end
    end

    assign out_vld  = vld_reg[NS-1];
    assign root_out = ROOT_W'(res_reg[NS-1]);
    assign side_out = side_reg[NS-1];

endmodule

[hdl/qsl_cordic_vec.sv]
// CORDIC vectoring pipeline: angle of (x, y) in Q.30, one micro-rotation per stage.
`timescale 1ns / 1ps

module qsl_cordic_vec #(
    parameter int STAGES = qsl_pkg::CORDIC_STAGES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            en,
    input  logic                            in_vld,
    input  logic signed [qsl_pkg::CW-1:0]   x_in,
    input  logic signed [qsl_pkg::CW-1:0]   y_in,
    input  qsl_pkg::side_t                  side_in,
    output logic                            out_vld,
    output logic signed [qsl_pkg::CW-1:0]   z_out,
    output qsl_pkg::side_t                  side_out
);
    import qsl_pkg::*;

    logic                 vld_reg  [STAGES];
    logic signed [CW-1:0] x_reg    [STAGES];
    logic signed [CW-1:0] y_reg    [STAGES];
    logic signed [CW-1:0] z_reg    [STAGES];
    side_t                side_reg [STAGES];

    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        localparam logic signed [CW-1:0] ATN = CW'(atan_q30(i));

        logic                 vld_i;
        logic signed [CW-1:0] x_i;
        logic signed [CW-1:0] y_i;
        logic signed [CW-1:0] z_i;
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
        side_t                side_i;

        if (i == 0) begin : g_first
            assign vld_i  = in_vld;
            assign x_i    = x_in;
            assign y_i    = y_in;
            assign z_i    = '0;
            assign side_i = side_in;
        end else begin : g_next
            assign vld_i  = vld_reg[i-1];
            assign x_i    = x_reg[i-1];
            assign y_i    = y_reg[i-1];
            assign z_i    = z_reg[i-1];
            assign side_i = side_reg[i-1];
        end

        assign dx = y_i >>> i;
        assign dy = x_i >>> i;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i] <= 1'b0;
            end else if (en) begin
                vld_reg[i] <= vld_i;
            end
        end

        // drive y toward zero, accumulate the angle
        always_ff @(posedge aclk) begin
            if (en) begin
                side_reg[i] <= side_i;
                if (y_i > 0) begin
                    x_reg[i] <= x_i + dx;
                    y_reg[i] <= y_i - dy;
                    z_reg[i] <= z_i + ATN;
                end else begin
                    x_reg[i] <= x_i - dx;
                    y_reg[i] <= y_i + dy;
                    z_reg[i] <= z_i - ATN;
                end
            end
        end
    end

    assign out_vld  = vld_reg[STAGES-1];
    assign z_out    = z_reg[STAGES-1];
    assign side_out = side_reg[STAGES-1];

endmodule

[hdl/qsl_cordic_rot.sv]
// CORDIC rotation pipeline: unscaled sine of several angles in parallel lanes.
`timescale 1ns / 1ps

module qsl_cordic_rot #(
    parameter int STAGES = qsl_pkg::CORDIC_STAGES_DEF,
    parameter int LANES  = qsl_pkg::ROT_LANES
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                en,
    input  logic                                in_vld,
    input  logic [LANES-1:0][qsl_pkg::CW-1:0]   z_in,
    input  qsl_pkg::side_t                      side_in,
    output logic                                out_vld,
    output logic [LANES-1:0][qsl_pkg::CW-1:0]   y_out,
    output qsl_pkg::side_t                      side_out
);
    import qsl_pkg::*;

    localparam logic signed [CW-1:0] X0 = CW'(1) << 30;

    logic                 vld_reg  [STAGES];
    logic signed [CW-1:0] x_reg    [STAGES][LANES];
    logic signed [CW-1:0] y_reg    [STAGES][LANES];
    logic signed [CW-1:0] z_reg    [STAGES][LANES];
    side_t                side_reg [STAGES];

    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        localparam logic signed [CW-1:0] ATN = CW'(atan_q30(i));

        logic  vld_i;
        side_t side_i;

        if (i == 0) begin : g_first
            assign vld_i  = in_vld;
            assign side_i = side_in;
        end else begin : g_next
            assign vld_i  = vld_reg[i-1];
            assign side_i = side_reg[i-1];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i] <= 1'b0;
            end else if (en) begin
                vld_reg[i] <= vld_i;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                side_reg[i] <= side_i;
            end
        end

        for (genvar l = 0; l < LANES; l++) begin : g_lane
            logic signed [CW-1:0] x_i;
            logic signed [CW-1:0] y_i;
            logic signed [CW-1:0] z_i;
            logic signed [CW-1:0] dx;
            logic signed [CW-1:0] dy;

            if (i == 0) begin : g_first
                assign x_i = X0;
                assign y_i = '0;
                assign z_i = $signed(z_in[l]);
            end else begin : g_next
                assign x_i = x_reg[i-1][l];
                assign y_i = y_reg[i-1][l];
                assign z_i = z_reg[i-1][l];
            end

            assign dx = y_i >>> i;
            assign dy = x_i >>> i;

            // rotate toward the residual angle
            always_ff @(posedge aclk) begin
                if (en) begin
                    if (z_i >= 0) begin
                        x_reg[i][l] <= x_i - dx;
                        y_reg[i][l] <= y_i + dy;
                        z_reg[i][l] <= z_i - ATN;
                    end else begin
                        x_reg[i][l] <= x_i + dx;
                        y_reg[i][l] <= y_i - dy;
                        z_reg[i][l] <= z_i + ATN;
                    end
                end
            end
        end
    end

    // lane results from the last stage
    for (genvar l = 0; l < LANES; l++) begin : g_out
        assign y_out[l] = y_reg[STAGES-1][l];
    end

    assign out_vld  = vld_reg[STAGES-1];
    assign side_out = side_reg[STAGES-1];

endmodule

[hdl/qsl_div.sv]
// Pipelined restoring divider for the Q.16 weights, capped at 1.0, lanes share a divisor.
`timescale 1ns / 1ps

module qsl_div #(
    parameter int LANES = qsl_pkg::DIV_LANES
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                en,
    input  logic                                in_vld,
    input  logic [LANES-1:0][qsl_pkg::CW-1:0]   num_in,
    input  logic signed [qsl_pkg::CW-1:0]       den_in,
    input  qsl_pkg::side_t                      side_in,
    output logic                                out_vld,
    output logic [LANES-1:0][qsl_pkg::QW-1:0]   q_out,
    output qsl_pkg::side_t                      side_out
);
    import qsl_pkg::*;

    logic          vld_reg  [QW];
    logic [CW-1:0] den_reg  [QW];
    side_t         side_reg [QW];
    logic [CW-1:0] r_reg    [QW][LANES];
    logic [QW-1:0] q_reg    [QW][LANES];
    logic          zero_reg [QW][LANES];
    logic          ovf_reg  [QW][LANES];

    for (genvar j = 0; j < QW; j++) begin : g_stage
        logic          vld_i;
        logic [CW-1:0] den_i;
        side_t         side_i;

        if (j == 0) begin : g_first
            assign vld_i  = in_vld;
            assign den_i  = den_in;
            assign side_i = side_in;
        end else begin : g_next
            assign vld_i  = vld_reg[j-1];
            assign den_i  = den_reg[j-1];
            assign side_i = side_reg[j-1];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[j] <= 1'b0;
            end else if (en) begin
                vld_reg[j] <= vld_i;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                den_reg[j]  <= den_i;
                side_reg[j] <= side_i;
            end
        end

        for (genvar l = 0; l < LANES; l++) begin : g_lane
            logic [CW-1:0] rs;
            logic [QW-1:0] q_i;
            logic          zero_i;
            logic          ovf_i;

            // first stage takes the integer quotient bit and flags the special cases
            if (j == 0) begin : g_first
                assign rs     = num_in[l];
                assign q_i    = '0;
                assign zero_i = ($signed(num_in[l]) <= 0);
                assign ovf_i  = ($signed({num_in[l][CW-1], num_in[l]}) >=
                                 $signed({den_in, 1'b0}));
            end else begin : g_next
                assign rs     = {r_reg[j-1][l][CW-2:0], 1'b0};
                assign q_i    = q_reg[j-1][l];
                assign zero_i = zero_reg[j-1][l];
                assign ovf_i  = ovf_reg[j-1][l];
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    zero_reg[j][l] <= zero_i;
                    ovf_reg[j][l]  <= ovf_i;
                    if (rs >= den_i) begin
                        r_reg[j][l] <= rs - den_i;
                        q_reg[j][l] <= {q_i[QW-2:0], 1'b1};
                    end else begin
                        r_reg[j][l] <= rs;
                        q_reg[j][l] <= {q_i[QW-2:0], 1'b0};
                    end
                end
            end
        end
    end

    // non-positive sine gives zero weight, large quotients cap at 1.0
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            if (zero_reg[QW-1][l]) begin
                q_out[l] = '0;
            end else if (ovf_reg[QW-1][l] || (q_reg[QW-1][l] > ONE_Q16)) begin
                q_out[l] = ONE_Q16;
            end else begin
                q_out[l] = q_reg[QW-1][l];
            end
        end
    end

    assign out_vld  = vld_reg[QW-1];
    assign side_out = side_reg[QW-1];

endmodule

[dv/quaternion_slerp_checker.sv]
// Checker for the quaternion slerp block: predicts each result and compares it.
`timescale 1ns / 1ps

module quaternion_slerp_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [14:0]        cfg_linear_cos_threshold,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic signed [15:0] s_start_w,
    input  logic signed [15:0] s_start_x,
    input  logic signed [15:0] s_start_y,
    input  logic signed [15:0] s_start_z,
    input  logic signed [15:0] s_end_w,
    input  logic signed [15:0] s_end_x,
    input  logic signed [15:0] s_end_y,
    input  logic signed [15:0] s_end_z,
    input  logic signed [17:0] s_blend_fraction,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic signed [15:0] m_out_w,
    input  logic signed [15:0] m_out_x,
    input  logic signed [15:0] m_out_y,
    input  logic signed [15:0] m_out_z,
    input  logic               m_result_valid,
    output int                 fail_count,
    output int                 pending_count,
    output int                 result_count
);

    typedef struct packed {
        logic signed [3:0][15:0] comp;
        logic                    ok;
    } blend_t;

    localparam int STAGES = qsl_pkg::CORDIC_STAGES_DEF;
    localparam longint ONE16 = 65536;

    blend_t      blend_q[$];
    logic [14:0] cos_thr;

    // floor division by 2^s for signed values
    function automatic longint shr_floor(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic longint root_floor(input longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // vectoring pass: angle of (x, y)
    function automatic longint vec_angle(input longint x, input longint y);
        longint z, dx, dy;
        z = 0;
        for (int i = 0; i < STAGES; i++) begin
            dx = shr_floor(y, i);
            dy = shr_floor(x, i);
            if (y > 0) begin
                x += dx; y -= dy; z += longint'(qsl_pkg::atan_q30(i));
            end else begin
                x -= dx; y += dy; z -= longint'(qsl_pkg::atan_q30(i));
            end
        end
        return z;
    endfunction

    // rotation pass from (1.0, 0): unscaled sine
    function automatic longint rot_sine(input longint z);
        longint x, y, dx, dy;
        x = 64'sd1 << 30;
        y = 0;
        for (int i = 0; i < STAGES; i++) begin
            dx = shr_floor(y, i);
            dy = shr_floor(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(qsl_pkg::atan_q30(i));
            end else begin
                x += dx; y -= dy; z += longint'(qsl_pkg::atan_q30(i));
            end
        end
        return y;
    endfunction

    function automatic longint sine_ratio(input longint y, input longint ys);
        longint q;
        if (y <= 0) return 0;
        q = (y <<< 16) / ys;
        return (q > ONE16) ? ONE16 : q;
    endfunction

    function automatic blend_t slerp_predict(input logic signed [3:0][15:0] sq,
                                             input logic signed [3:0][15:0] eq,
                                             input logic signed [17:0] frac,
                                             input logic [14:0] thr);
        blend_t r;
        longint t, c, w0, w1, cq, sn, ang, ys, v;
        longint s[4], e[4];
        longint unsigned rad;
        r = '0;
        t = frac;
        if (t < 0 || t > ONE16) return r;
        c = 0;
        for (int k = 0; k < 4; k++) begin
            s[k] = $signed(sq[k]);
            e[k] = $signed(eq[k]);
            c += s[k] * e[k];
        end
        // shorter arc
        if (c < 0) begin
            for (int k = 0; k < 4; k++) e[k] = -e[k];
            c = -c;
        end
        w0 = ONE16 - t;
        w1 = t;
        if (!(c > (longint'(thr) <<< 14))) begin
            cq = (c > (64'sd1 << 28)) ? (64'sd1 << 30) : (c <<< 2);
            rad = (64'd1 << 60) - longint'(cq) * longint'(cq);
            sn = root_floor(rad);
            if (sn > 0) begin
                ang = vec_angle(cq, sn);
                if (ang < 0) ang = 0;
                ys = rot_sine(ang);
                if (ys > 0) begin
                    w0 = sine_ratio(rot_sine(((ONE16 - t) * ang) >>> 16), ys);
                    w1 = sine_ratio(rot_sine((t * ang) >>> 16), ys);
                end
            end
        end
        for (int k = 0; k < 4; k++) begin
            v = (s[k] * w0 + e[k] * w1 + 32768) >>> 16;
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            r.comp[k] = v[15:0];
        end
        r.ok = 1'b1;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    initial begin
        fail_count = 0;
        result_count = 0;
        pending_count = 0;
    end

    // track register, record requests, compare results
    always @(posedge aclk) begin
        blend_t want, got;
        if (!aresetn) begin
            cos_thr <= qsl_pkg::THR_RESET;
        end else begin
            if (cfg_valid && cfg_ready) cos_thr <= cfg_linear_cos_threshold;
            if (s_valid && s_ready)
                blend_q = {blend_q, slerp_predict(
                    {s_start_z, s_start_y, s_start_x, s_start_w},
                    {s_end_z, s_end_y, s_end_x, s_end_w}, s_blend_fraction, cos_thr)};
            if (m_valid && m_ready) begin
                result_count++;
                got.comp = {m_out_z, m_out_y, m_out_x, m_out_w};
                got.ok = m_result_valid;
                if (blend_q.size() == 0) begin
                    $display("%0t result with no request outstanding", $realtime);
                    fail_count++;
                end else begin
                    want = blend_q.pop_front();
                    if (got.ok !== want.ok) report_mismatch("result_valid", got.ok, want.ok);
                    for (int k = 0; k < 4; k++)
                        if (got.comp[k] !== want.comp[k])
                            report_mismatch($sformatf("component %0d", k),
                                            $signed(got.comp[k]), $signed(want.comp[k]));
                end
            end
        end
        pending_count <= blend_q.size();
    end

endmodule

[dv/quaternion_slerp_top_tb.sv]
// Testbench top for the quaternion slerp block: stimulus, idling and verdict.
`timescale 1ns / 1ps

module quaternion_slerp_top_tb;

    localparam int LATENCY = 2 * qsl_pkg::CORDIC_STAGES_DEF + 55;

    logic               aclk;
    logic               aresetn;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [14:0]        cfg_linear_cos_threshold;
    logic               s_valid;
    logic               s_ready;
    logic signed [15:0] s_start_w, s_start_x, s_start_y, s_start_z;
    logic signed [15:0] s_end_w, s_end_x, s_end_y, s_end_z;
    logic signed [17:0] s_blend_fraction;
    logic               m_valid;
    logic               m_ready;
    logic signed [15:0] m_out_w, m_out_x, m_out_y, m_out_z;
    logic               m_result_valid;
    int                 fail_count, pending_count, result_count;
    bit                 steady;
    int                 sent;

    quaternion_slerp_top dut (.*);

    quaternion_slerp_checker chk (.*);

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // hard stop
    initial begin
        #100ms;
        $display("timeout");
        $display("quaternion_slerp_top verification failed");
        $finish;
    end

    // receiver stalls, none while steady
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            m_ready <= steady || ($urandom_range(99) >= 22);
        end
    end

    function automatic logic signed [15:0] unit_comp();
        return $signed(16'($urandom_range(32768))) - 16'sd16384;
    endfunction

    // one request; holds until accepted, valid stays up for a back-to-back follower
    task automatic send_req(input logic signed [15:0] sw, sx, sy, sz, ew, ex, ey, ez,
                            input logic signed [17:0] frac);
        while (!steady && $urandom_range(99) < 22) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        {s_start_w, s_start_x, s_start_y, s_start_z} <= {sw, sx, sy, sz};
        {s_end_w, s_end_x, s_end_y, s_end_z} <= {ew, ex, ey, ez};
        s_blend_fraction <= frac;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        sent++;
    endtask

    task automatic set_threshold(input logic [14:0] thr);
        s_valid <= 1'b0;
        while (pending_count != 0) @(negedge aclk);
        repeat (LATENCY + 4) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_linear_cos_threshold <= thr;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // random request: mostly components within -1.0..1.0, some raw noise
    task automatic random_req();
        logic signed [15:0] q[8];
        logic signed [17:0] frac;
        int mode;
        mode = $urandom_range(9);
        for (int k = 0; k < 8; k++)
            q[k] = (mode < 3) ? 16'($urandom) : unit_comp();
        // end close to start for linear path
        if (mode == 9)
            for (int k = 0; k < 4; k++)
                q[4 + k] = q[k] + $signed(16'($urandom_range(6))) - 16'sd3;
        case ($urandom_range(9))
            0: frac = 18'($urandom);
            1: frac = 18'sd0;
            2: frac = 18'sd65536;
            default: frac = 18'($urandom_range(65536));
        endcase
        send_req(q[0], q[1], q[2], q[3], q[4], q[5], q[6], q[7], frac);
    endtask

    initial begin
        logic [14:0] thr_set[5];
        thr_set = '{15'd0, 15'd16384, 15'd12000, 15'd16376, 15'h7fff};
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_linear_cos_threshold = '0;
        s_valid = 1'b0;
        {s_start_w, s_start_x, s_start_y, s_start_z} = '0;
        {s_end_w, s_end_x, s_end_y, s_end_z} = '0;
        s_blend_fraction = '0;
        steady = 1'b0;
        sent = 0;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: extremes, invalid fractions, zero dot, opposite, identical
        send_req(16'sd16384, 0, 0, 0, 16'sd16384, 0, 0, 0, 18'sd32768);
        send_req(16'sd16384, 0, 0, 0, 0, 16'sd16384, 0, 0, 18'sd32768);
        send_req(16'sd16384, 0, 0, 0, -16'sd16384, 0, 0, 0, 18'sd16384);
        send_req(16'sd16384, 0, 0, 0, -16'sd11585, 16'sd11585, 0, 0, 18'sd0);
        send_req(16'sd16384, 0, 0, 0, -16'sd11585, 16'sd11585, 0, 0, 18'sd65536);
        send_req(16'sd16384, 0, 0, 0, 16'sd11585, 16'sd11585, 0, 0, -18'sd1);
        send_req(16'sd16384, 0, 0, 0, 16'sd11585, 16'sd11585, 0, 0, 18'sd65537);
        send_req(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 18'sd40000);
        send_req(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768,
                 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 18'sd20000);
        send_req(-16'sd32768, 16'sh7fff, -16'sd32768, 16'sh7fff,
                 16'sh7fff, -16'sd32768, 16'sh7fff, -16'sd32768, -18'sd131072);
        send_req(0, 0, 0, 0, 0, 0, 0, 0, 18'sd131071);
        send_req(0, 0, 0, 0, 0, 0, 0, 0, 18'sd30000);
        send_req(16'sd16384, 0, 0, 0, 16'sd16383, 16'sd100, 0, 0, 18'sd50000);
        send_req(16'sd16384, 16'sd16384, 0, 0, 16'sd16384, 16'sd16384, 0, 0, 18'sd10000);

        // random phases across threshold settings; one phase without idling
        foreach (thr_set[p]) begin
            set_threshold(thr_set[p]);
            steady = (p == 2);
            repeat (210) random_req();
            steady = 1'b0;
        end

        s_valid <= 1'b0;
        while (pending_count != 0) @(negedge aclk);
        repeat (LATENCY + 10) @(negedge aclk);
        $display("%0d requests sent, %0d results checked over %0d threshold settings",
                 sent, result_count, 5);
        if (fail_count == 0 && pending_count == 0) begin
            $display("quaternion_slerp_top verification clean");
        end else begin
            $display("quaternion_slerp_top verification failed");
        end
        $finish;
    end

endmodule

[quaternion_slerp_top.f]
hdl/qsl_pkg.sv
hdl/qsl_sqrt.sv
hdl/qsl_cordic_vec.sv
hdl/qsl_cordic_rot.sv
hdl/qsl_div.sv
hdl/quaternion_slerp_top.sv
dv/quaternion_slerp_checker.sv
dv/quaternion_slerp_top_tb.sv
